FILE: hw/rtl/ths_pkg.sv
`default_nettype none
package ths_pkg;

	typedef enum logic [1:0] {
		CFG_ORIGIN_X     = 2'd0,
		CFG_ORIGIN_Z     = 2'd1,
		CFG_CELL_SCALE   = 2'd2,
		CFG_VERTEX_COUNT = 2'd3
	} cfg_index_t;

	// height = round(|2s-765|*1792/153) = floor((2m+153)/306), m = |2s-765|*1792
	localparam logic [9:0]  PIX_MID     = 10'd765;
	localparam logic [7:0]  ROUND_BIAS  = 8'd153;
	localparam logic [8:0]  DIV_CONST   = 9'd306;
	// floor(2^32 / 306)
	localparam logic [23:0] DIV_RECIP   = 24'd14035840;
	localparam int          RECIP_SHIFT = 32;

	localparam logic [16:0] ONE_Q16     = 17'd65536;
	localparam logic [15:0] TRUNC_BIAS  = 16'hFFFF;

	localparam logic [23:0] ORIGIN_RESET = 24'd0;
	localparam logic [19:0] SCALE_RESET  = 20'd32768;
	localparam logic [8:0]  COUNT_RESET  = 9'd256;

endpackage
`default_nettype wire

FILE: hw/rtl/terrain_height_sampler.sv
`default_nettype none
// Terrain height sampler: an item is taken on any cycle with start high (busy stays low), so one
// load or query can enter every clock. Each query gives a result strobe at the end of the pipeline;
// loads give no result. The pipeline has five stages: offset, multiply by
// the cell scale, corner read from four parity-banked height memories, three weight products,
// then sum and truncate. The result lasts one cycle and cannot be held off by the receiver.
// Configuration writes are always ready; write them only while no query is in flight.
module terrain_height_sampler
	import ths_pkg::*;
#(
	parameter int GRID_MAX = 256
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire                kind,
	input  wire         [7:0]  load_row,
	input  wire         [7:0]  load_col,
	input  wire         [7:0]  red_level,
	input  wire         [7:0]  green_level,
	input  wire         [7:0]  blue_level,
	input  wire  signed [23:0] query_x,
	input  wire  signed [23:0] query_z,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire         [1:0]  cfg_index,
	input  wire         [23:0] cfg_data,
	output logic               result_valid,
	output logic signed [14:0] height_out,
	output logic               outside
);

	localparam int RW    = (GRID_MAX > 2) ? $clog2(GRID_MAX) : 1;
	localparam int HW    = (RW > 1) ? RW - 1 : 1;
	localparam int HG    = (GRID_MAX + 1) / 2;
	localparam int DEPTH = HG * HG;
	localparam int BAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int VW    = $clog2(GRID_MAX + 1) + 1;
	localparam int CW    = (VW > 9) ? VW : 9;

	logic signed [23:0] origin_x_q, origin_z_q;
	logic [19:0]        cell_scale_q;
	logic [8:0]         vertex_count_q;
	logic [CW-1:0]      vc;

	logic               accept;
	logic [9:0]         pix_sum;
	logic signed [11:0] pix_d;
	logic [9:0]         pix_abs;
	logic [20:0]        pix_m;
	logic [21:0]        pix_x;
	logic               load_ok;

	logic               v_s1, kind_s1, ok_s1, neg_s1;
	logic [RW-1:0]      row_s1, col_s1;
	logic [21:0]        x_s1;
	logic signed [24:0] tx_s1, tz_s1;

	logic               v_s2, kind_s2, ok_s2, neg_s2, tneg_s2;
	logic [RW-1:0]      row_s2, col_s2;
	logic [45:0]        prod_s2;
	logic [21:0]        x_s2;
	logic [43:0]        ax_s2, az_s2;

	logic [13:0]        q0;
	logic [21:0]        rem;
	logic [13:0]        qh;
	logic [14:0]        load_h;
	logic               we;
	logic [1:0]         wbank;
	logic [BAW-1:0]     waddr;
	logic [19:0]        gx, gz;
	logic [15:0]        fx, fz;
	logic               off_q, tri_up;
	logic [16:0]        w_diag, w01, w10;
	logic [BAW-1:0]     raddr [4];

	logic               v_s3, off_s3, tri_s3;
	logic [1:0]         par_s3;
	logic [16:0]        wd_s3, w01_s3, w10_s3;
	logic signed [14:0] rd_s3 [4];
	logic [14:0]        mem [4][DEPTH];

	logic signed [14:0] h_diag, h01, h10;
	logic               v_s4, off_s4;
	logic signed [32:0] pd_s4, p01_s4, p10_s4;
	logic signed [34:0] sum;
	logic signed [34:0] sum_b;
	logic signed [14:0] hq;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q     <= ORIGIN_RESET;
			origin_z_q     <= ORIGIN_RESET;
			cell_scale_q   <= SCALE_RESET;
			vertex_count_q <= COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_ORIGIN_X:     origin_x_q     <= cfg_data;
				CFG_ORIGIN_Z:     origin_z_q     <= cfg_data;
				CFG_CELL_SCALE:   cell_scale_q   <= cfg_data[19:0];
				CFG_VERTEX_COUNT: vertex_count_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	assign vc = (CW'(vertex_count_q) < CW'(GRID_MAX)) ? CW'(vertex_count_q) : CW'(GRID_MAX);

	// load height front end
	always_comb begin
		pix_sum = 10'(red_level) + 10'(green_level) + 10'(blue_level);
		pix_d   = $signed({1'b0, pix_sum, 1'b0}) - $signed({2'b0, PIX_MID});
		pix_abs = pix_d[11] ? 10'(-pix_d) : pix_d[9:0];
		pix_m   = (21'(pix_abs) << 11) - (21'(pix_abs) << 8);
		pix_x   = {pix_m, 1'b0} + 22'(ROUND_BIAS);
		load_ok = (CW'(load_row) < vc) && (CW'(load_col) < vc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= kind;
		ok_s1   <= load_ok;
		neg_s1  <= pix_d[11];
		row_s1  <= RW'(load_row);
		col_s1  <= RW'(load_col);
		x_s1    <= pix_x;
		tx_s1   <= $signed({query_x[23], query_x}) - $signed({origin_x_q[23], origin_x_q});
		tz_s1   <= $signed({query_z[23], query_z}) - $signed({origin_z_q[23], origin_z_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind_s2 <= kind_s1;
		ok_s2   <= ok_s1;
		neg_s2  <= neg_s1;
		row_s2  <= row_s1;
		col_s2  <= col_s1;
		x_s2    <= x_s1;
		prod_s2 <= 46'(x_s1) * 46'(DIV_RECIP);
		ax_s2   <= 44'(tx_s1[23:0]) * 44'(cell_scale_q);
		az_s2   <= 44'(tz_s1[23:0]) * 44'(cell_scale_q);
		tneg_s2 <= tx_s1[24] || tz_s1[24];
	end

	// load finish and query addressing
	always_comb begin
		q0     = prod_s2[RECIP_SHIFT +: 14];
		rem    = x_s2 - 22'(q0) * 22'(DIV_CONST);
		qh     = (rem >= 22'(DIV_CONST)) ? q0 + 14'd1 : q0;
		load_h = neg_s2 ? 15'(-$signed({1'b0, qh})) : {1'b0, qh};
		we     = v_s2 && !kind_s2 && ok_s2;
		wbank  = {row_s2[0], col_s2[0]};
		waddr  = BAW'(BAW'(HW'(row_s2 >> 1)) * BAW'(HG) + BAW'(HW'(col_s2 >> 1)));

		gx     = ax_s2[43:24];
		gz     = az_s2[43:24];
		fx     = ax_s2[23:8];
		fz     = az_s2[23:8];
		off_q  = tneg_s2 || (vc < CW'(2)
			|| (21'(gx) >= 21'(vc) - 21'd1) || (21'(gz) >= 21'(vc) - 21'd1));
		tri_up = (17'(fx) + 17'(fz)) > ONE_Q16;
		if (tri_up) begin
			w_diag = 17'(fx) + 17'(fz) - ONE_Q16;
			w01    = ONE_Q16 - 17'(fz);
			w10    = ONE_Q16 - 17'(fx);
		end else begin
			w_diag = ONE_Q16 - 17'(fx) - 17'(fz);
			w01    = 17'(fx);
			w10    = 17'(fz);
		end
		for (int b = 0; b < 4; b++) begin
			raddr[b] = BAW'(BAW'(HW'((RW'(gz) + RW'((b >> 1) ^ int'(gz[0]))) >> 1)) * BAW'(HG)
				+ BAW'(HW'((RW'(gx) + RW'((b & 1) ^ int'(gx[0]))) >> 1)));
		end
	end

	for (genvar b = 0; b < 4; b++) begin : g_bank
		always_ff @(posedge clk) begin
			if (we && wbank == 2'(b)) begin
				mem[b][waddr] <= load_h;
			end
			rd_s3[b] <= mem[b][raddr[b]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2 && kind_s2;
		end
	end

	always_ff @(posedge clk) begin
		off_s3 <= off_q;
		tri_s3 <= tri_up;
		par_s3 <= {gz[0], gx[0]};
		wd_s3  <= w_diag;
		w01_s3 <= w01;
		w10_s3 <= w10;
	end

	always_comb begin
		h_diag = tri_s3 ? rd_s3[par_s3 ^ 2'b11] : rd_s3[par_s3];
		h01    = rd_s3[par_s3 ^ 2'b01];
		h10    = rd_s3[par_s3 ^ 2'b10];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		off_s4 <= off_s3;
		pd_s4  <= $signed({1'b0, wd_s3}) * h_diag;
		p01_s4 <= $signed({1'b0, w01_s3}) * h01;
		p10_s4 <= $signed({1'b0, w10_s3}) * h10;
	end

	// truncate toward zero
	always_comb begin
		sum   = 35'(pd_s4) + 35'(p01_s4) + 35'(p10_s4);
		sum_b = sum + (sum[34] ? $signed(35'(TRUNC_BIAS)) : 35'sd0);
		hq    = sum_b[30:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		outside    <= off_s4;
		height_out <= off_s4 ? 15'sd0 : hq;
	end

`ifndef SYNTHESIS
	a_result_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy && kind, 5))
		else $error("result without a query");
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && outside |-> height_out == 15'sd0)
		else $error("outside result not zero");
	a_weights_unity: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !off_s3 |-> (18'(wd_s3) + 18'(w01_s3) + 18'(w10_s3)) == 18'(ONE_Q16))
		else $error("barycentric weights do not sum to one");
`endif

endmodule
`default_nettype wire
